// ===== rtl/tga_dec_pkg.sv =====
package tga_dec_pkg;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_IDSKIP = 5'b00010,
    PH_PACKET = 5'b00100,
    PH_PIXEL  = 5'b01000,
    PH_IDLE   = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DEPTH = 2'd1,
    ST_CLIPPED   = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       end_of_image;
    status_e    status;
  } result_t;

  // header byte positions
  localparam logic [4:0] HdrIdLen   = 5'd0;
  localparam logic [4:0] HdrKind    = 5'd2;
  localparam logic [4:0] HdrWidthLo = 5'd12;
  localparam logic [4:0] HdrWidthHi = 5'd13;
  localparam logic [4:0] HdrHeightLo = 5'd14;
  localparam logic [4:0] HdrHeightHi = 5'd15;
  localparam logic [4:0] HdrDepth   = 5'd16;
  localparam logic [4:0] HdrLast    = 5'd17;

  localparam logic [7:0] KindRawColor = 8'd2;
  localparam logic [7:0] KindRawGray  = 8'd3;
  localparam logic [7:0] Depth24      = 8'd24;
  localparam logic [7:0] Depth32      = 8'd32;
  localparam logic [7:0] RunBias      = 8'd127;
  localparam logic [7:0] AlphaOpaque  = 8'd255;

  localparam logic [1:0] ByteLast24 = 2'd2;
  localparam logic [1:0] ByteLast32 = 2'd3;

endpackage

// ===== rtl/tga_dec_ctrl.sv =====
module tga_dec_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 frame_start_i,
  output logic                 res_valid_o,
  output tga_dec_pkg::result_t res_o
);
  import tga_dec_pkg::*;

  phase_e      phase_q, phase_d, phase_cur;
  logic [4:0]  hdr_idx_q, hdr_idx_d, hdr_idx_cur;
  logic [7:0]  id_skip_q, id_skip_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  depth_q, depth_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [31:0] pix_left_q, pix_left_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic        pkt_run_q, pkt_run_d;
  logic [1:0]  bip_q, bip_d;
  logic [7:0]  pb_q [3];
  logic [31:0] area_q;

  logic        raw_img, is32, depth_ok, clip;
  logic [1:0]  byte_last;
  logic [7:0]  rep, pkt_next;
  logic [31:0] pix_next;
  phase_e      data_phase;

  assign raw_img    = (kind_q == KindRawColor) || (kind_q == KindRawGray);
  assign is32       = (depth_q == Depth32);
  assign depth_ok   = (depth_q == Depth24) || is32;
  assign byte_last  = is32 ? ByteLast32 : ByteLast24;
  assign data_phase = raw_img ? PH_PIXEL : PH_PACKET;
  assign phase_cur  = frame_start_i ? PH_HEADER : phase_q;
  assign hdr_idx_cur = frame_start_i ? HdrIdLen : hdr_idx_q;

  // run/pixel accounting for the final byte of a pixel
  assign clip = !raw_img && pkt_run_q && ({24'b0, pkt_left_q} > pix_left_q);
  always_comb begin
    if (raw_img || !pkt_run_q) begin
      rep = 8'd1;
    end else if (clip) begin
      rep = pix_left_q[7:0];
    end else begin
      rep = pkt_left_q;
    end
    if (raw_img) begin
      pkt_next = pkt_left_q;
    end else if (pkt_run_q) begin
      pkt_next = 8'd0;
    end else begin
      pkt_next = pkt_left_q - 8'd1;
    end
  end
  assign pix_next = pix_left_q - {24'b0, rep};

  always_comb begin
    phase_d    = phase_cur;
    hdr_idx_d  = hdr_idx_cur;
    id_skip_d  = id_skip_q;
    kind_d     = kind_q;
    depth_d    = depth_q;
    width_d    = width_q;
    height_d   = height_q;
    pix_left_d = pix_left_q;
    pkt_left_d = pkt_left_q;
    pkt_run_d  = pkt_run_q;
    bip_d      = bip_q;
    res_valid_o = 1'b0;
    res_o = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0,
              repeat_count: 8'd0, end_of_image: 1'b0, status: ST_OK};

    unique case (phase_cur)
      PH_HEADER: begin
        unique case (hdr_idx_cur)
          HdrIdLen:    id_skip_d = data_byte_i;
          HdrKind:     kind_d = data_byte_i;
          HdrWidthLo:  width_d = {width_q[15:8], data_byte_i};
          HdrWidthHi:  width_d = {data_byte_i, width_q[7:0]};
          HdrHeightLo: height_d = {height_q[15:8], data_byte_i};
          HdrHeightHi: height_d = {data_byte_i, height_q[7:0]};
          HdrDepth:    depth_d = data_byte_i;
          default: ;
        endcase
        if (hdr_idx_cur != HdrLast) begin
          hdr_idx_d = hdr_idx_cur + 5'd1;
        end else begin
          hdr_idx_d  = HdrIdLen;
          pix_left_d = area_q;
          pkt_left_d = 8'd0;
          pkt_run_d  = 1'b0;
          bip_d      = 2'd0;
          if (!depth_ok) begin
            phase_d      = PH_IDLE;
            pix_left_d   = pix_left_q;
            pkt_left_d   = pkt_left_q;
            pkt_run_d    = pkt_run_q;
            bip_d        = bip_q;
            res_valid_o  = 1'b1;
            res_o.end_of_image = 1'b1;
            res_o.status = ST_BAD_DEPTH;
          end else if (area_q == 32'd0) begin
            phase_d     = PH_IDLE;
            bip_d       = bip_q;
            res_valid_o = 1'b1;
            res_o.end_of_image = 1'b1;
          end else if (id_skip_q != 8'd0) begin
            phase_d = PH_IDSKIP;
            bip_d   = bip_q;
          end else begin
            phase_d = data_phase;
          end
        end
      end
      PH_IDSKIP: begin
        id_skip_d = id_skip_q - 8'd1;
        if (id_skip_q == 8'd1) begin
          phase_d = data_phase;
          bip_d   = 2'd0;
        end
      end
      PH_PACKET: begin
        pkt_run_d  = data_byte_i[7];
        pkt_left_d = data_byte_i[7] ? (data_byte_i - RunBias) : (data_byte_i + 8'd1);
        phase_d    = PH_PIXEL;
        bip_d      = 2'd0;
      end
      PH_PIXEL: begin
        if (bip_q != byte_last) begin
          bip_d = bip_q + 2'd1;
        end else begin
          bip_d      = 2'd0;
          pix_left_d = pix_next;
          pkt_left_d = pkt_next;
          res_valid_o = 1'b1;
          res_o.red   = is32 ? pb_q[2] : data_byte_i;
          res_o.green = pb_q[1];
          res_o.blue  = pb_q[0];
          res_o.alpha = is32 ? data_byte_i : AlphaOpaque;
          res_o.repeat_count = rep;
          if (clip) begin
            res_o.status = ST_CLIPPED;
          end
          if (pix_next == 32'd0) begin
            res_o.end_of_image = 1'b1;
            phase_d = PH_IDLE;
            if (!raw_img && pkt_next != 8'd0) begin
              res_o.status = ST_CLIPPED;
            end
          end else if (!raw_img && pkt_next == 8'd0) begin
            phase_d = PH_PACKET;
          end
        end
      end
      PH_IDLE: ;
      default: ;
    endcase
    if (!in_valid_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_idx_q  <= 5'd0;
      id_skip_q  <= 8'd0;
      kind_q     <= 8'd0;
      depth_q    <= 8'd0;
      width_q    <= 16'd0;
      height_q   <= 16'd0;
      pix_left_q <= 32'd0;
      pkt_left_q <= 8'd0;
      pkt_run_q  <= 1'b0;
      bip_q      <= 2'd0;
    end else if (in_valid_i) begin
      phase_q    <= phase_d;
      hdr_idx_q  <= hdr_idx_d;
      id_skip_q  <= id_skip_d;
      kind_q     <= kind_d;
      depth_q    <= depth_d;
      width_q    <= width_d;
      height_q   <= height_d;
      pix_left_q <= pix_left_d;
      pkt_left_q <= pkt_left_d;
      pkt_run_q  <= pkt_run_d;
      bip_q      <= bip_d;
    end
  end

  // width and height settle two header bytes before the last one
  always_ff @(posedge clk_i) begin
    area_q <= 32'(width_q) * 32'(height_q);
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && phase_cur == PH_PIXEL && bip_q != ByteLast32) begin
      pb_q[bip_q] <= data_byte_i;
    end
  end

endmodule

// ===== rtl/tga_dec_outbuf.sv =====
module tga_dec_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tga_dec_pkg::result_t push_data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output tga_dec_pkg::result_t data_o
);
  import tga_dec_pkg::*;

  result_t out_q, skid_q;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    pop;

  assign pop     = out_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    priority if (pop && skid_valid_q) begin
      skid_valid_d = 1'b0;
    end else if (pop || !out_valid_q) begin
      out_valid_d = push_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if ((pop || !out_valid_q) && push_i) begin
      out_q <= push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

// ===== rtl/tga_rle_pixel_decoder_core.sv =====
// TGA pixel decoder: takes a TGA file one byte per transaction (tuser high on
// header byte 0), parses the 18-byte header, skips the ID field and returns
// RGBA pixels with a repeat count for raw (types 2, 3) and RLE images. A
// byte can be accepted every cycle while tready is high; a pixel result
// leaves from a registered output stage after its last byte. A
// two-entry output stage keeps tready high while one result waits; tready
// drops only when both entries are full. The image area is formed by one
// registered 16x16 multiply during the header, so no stall occurs there.
module tga_rle_pixel_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // red, green, blue, alpha, repeat_count
  output logic        m_axis_tlast,  // end_of_image
  output logic [1:0]  m_axis_tuser   // [1:0] status
);
  import tga_dec_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res, out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  tga_dec_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (accept),
    .data_byte_i   (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  tga_dec_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = {out_res.repeat_count, out_res.alpha, out_res.blue,
                         out_res.green, out_res.red};
  assign m_axis_tlast = out_res.end_of_image;
  assign m_axis_tuser = out_res.status;

endmodule

// ===== test/tb_tga_rle_pixel_decoder_core.sv =====
`timescale 1ns / 100ps

module tb_tga_rle_pixel_decoder_core;
  import tga_dec_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned DrainCycles = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;  // [7:0] data_byte
  logic        s_axis_tuser;  // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;  // red, green, blue, alpha, repeat_count
  logic        m_axis_tlast;  // end_of_image
  logic [1:0]  m_axis_tuser;  // [1:0] status

  tga_rle_pixel_decoder_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // decoder state mirrored by the pixel predictor
  phase_e      dec_phase;
  logic [4:0]  hdr_pos;
  logic [7:0]  id_left;
  logic [7:0]  img_kind;
  logic [7:0]  bits_pp;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [31:0] px_left;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [1:0]  px_byte;
  logic [7:0]  px_buf [3];

  result_t     pending_pixels [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned decoded_bytes;
  int unsigned pixels_checked;
  int unsigned mismatches;
  int unsigned cycle_count;

  function automatic bit is_raw_kind();
    return img_kind == KindRawColor || img_kind == KindRawGray;
  endfunction

  task automatic enter_pixel_data();
    dec_phase = is_raw_kind() ? PH_PIXEL : PH_PACKET;
    px_byte   = '0;
  endtask

  // Advance the predicted decoder by one accepted byte; queue any pixel it yields.
  task automatic decode_tga_byte(input logic [7:0] d, input logic fs);
    result_t    px;
    logic [1:0] last_idx;
    logic [7:0] rep;
    px = '0;
    if (fs) begin
      dec_phase = PH_HEADER;
      hdr_pos   = '0;
    end
    if (dec_phase != PH_IDLE) decoded_bytes++;
    case (dec_phase)
      PH_HEADER: begin
        case (hdr_pos)
          HdrIdLen:    id_left = d;
          HdrKind:     img_kind = d;
          HdrWidthLo:  img_w[7:0] = d;
          HdrWidthHi:  img_w[15:8] = d;
          HdrHeightLo: img_h[7:0] = d;
          HdrHeightHi: img_h[15:8] = d;
          HdrDepth:    bits_pp = d;
          default: ;
        endcase
        if (hdr_pos != HdrLast) begin
          hdr_pos = hdr_pos + 5'd1;
        end else begin
          hdr_pos = '0;
          if (bits_pp != Depth24 && bits_pp != Depth32) begin
            dec_phase       = PH_IDLE;
            px.end_of_image = 1'b1;
            px.status       = ST_BAD_DEPTH;
            pending_pixels.push_back(px);
          end else begin
            px_left  = 32'(img_w) * 32'(img_h);
            pkt_left = '0;
            pkt_run  = 1'b0;
            if (px_left == 0) begin
              dec_phase       = PH_IDLE;
              px.end_of_image = 1'b1;
              px.status       = ST_OK;
              pending_pixels.push_back(px);
            end else if (id_left != 0) begin
              dec_phase = PH_IDSKIP;
            end else begin
              enter_pixel_data();
            end
          end
        end
      end
      PH_IDSKIP: begin
        id_left = id_left - 8'd1;
        if (id_left == 0) enter_pixel_data();
      end
      PH_PACKET: begin
        if (!d[7]) begin
          pkt_run  = 1'b0;
          pkt_left = d + 8'd1;
        end else begin
          pkt_run  = 1'b1;
          pkt_left = d - RunBias;
        end
        dec_phase = PH_PIXEL;
        px_byte   = '0;
      end
      PH_PIXEL: begin
        last_idx = (bits_pp == Depth32) ? ByteLast32 : ByteLast24;
        if (px_byte < 2'd3) px_buf[px_byte] = d;
        if (px_byte < last_idx) begin
          px_byte = px_byte + 2'd1;
        end else begin
          px.alpha  = (last_idx == ByteLast32) ? d : AlphaOpaque;
          px.status = ST_OK;
          px_byte   = '0;
          if (is_raw_kind()) begin
            rep = 8'd1;
          end else if (pkt_run) begin
            rep = pkt_left;
            if (32'(rep) > px_left) begin
              rep       = px_left[7:0];
              px.status = ST_CLIPPED;
            end
            pkt_left = '0;
          end else begin
            rep      = 8'd1;
            pkt_left = pkt_left - 8'd1;
          end
          px_left = px_left - 32'(rep);
          if (px_left == 0) begin
            px.end_of_image = 1'b1;
            if (!is_raw_kind() && pkt_left != 0) px.status = ST_CLIPPED;
            dec_phase = PH_IDLE;
          end else if (!is_raw_kind() && pkt_left == 0) begin
            dec_phase = PH_PACKET;
          end
          px.red          = px_buf[2];
          px.green        = px_buf[1];
          px.blue         = px_buf[0];
          px.repeat_count = rep;
          pending_pixels.push_back(px);
        end
      end
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic [7:0] b, input logic fs);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= fs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_tga_byte(b, fs);
    @(negedge clk_i);
  endtask

  task automatic send_header(input logic fs, input logic [7:0] id_len,
                             input logic [7:0] kind, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] depth);
    logic [7:0] b;
    for (int i = 0; i <= int'(HdrLast); i++) begin
      case (5'(i))
        HdrIdLen:    b = id_len;
        HdrKind:     b = kind;
        HdrWidthLo:  b = w[7:0];
        HdrWidthHi:  b = w[15:8];
        HdrHeightLo: b = h[7:0];
        HdrHeightHi: b = h[15:8];
        HdrDepth:    b = depth;
        default:     b = 8'($urandom);
      endcase
      send_byte(b, (i == 0) ? fs : 1'b0);
    end
  endtask

  // file order is blue, green, red, then alpha on 32-bit data
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] a, input bit wide);
    send_byte(b, 1'b0);
    send_byte(g, 1'b0);
    send_byte(r, 1'b0);
    if (wide) send_byte(a, 1'b0);
  endtask

  task automatic send_rand_bytes(input int unsigned n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_rand_pixels(input int unsigned n, input bit wide);
    repeat (n) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), wide);
  endtask

  // Hold the sender off until every predicted pixel has come out.
  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_pixels.size() != 0);
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin : check_pixels
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.red          = m_axis_tdata[7:0];
      got.green        = m_axis_tdata[15:8];
      got.blue         = m_axis_tdata[23:16];
      got.alpha        = m_axis_tdata[31:24];
      got.repeat_count = m_axis_tdata[39:32];
      got.end_of_image = m_axis_tlast;
      got.status       = status_e'(m_axis_tuser);
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: r=%0d g=%0d b=%0d a=%0d rep=%0d eoi=%0b st=%0d",
                   got.red, got.green, got.blue, got.alpha, got.repeat_count,
                   got.end_of_image, got.status);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.repeat_count !== want.repeat_count ||
            got.end_of_image !== want.end_of_image || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pixel %0d expected: r=%0d g=%0d b=%0d a=%0d rep=%0d eoi=%0b st=%0d",
                     pixels_checked, want.red, want.green, want.blue, want.alpha,
                     want.repeat_count, want.end_of_image, want.status);
            $display("pixel %0d actual:   r=%0d g=%0d b=%0d a=%0d rep=%0d eoi=%0b st=%0d",
                     pixels_checked, got.red, got.green, got.blue, got.alpha,
                     got.repeat_count, got.end_of_image, got.status);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d pixels outstanding",
               cycle_count, pending_pixels.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // header parsed from byte 0 right after reset, no frame start seen yet
  task automatic test_no_frame_start();
    send_header(1'b0, 8'd0, KindRawColor, 16'd2, 16'd1, Depth24);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_rand_bytes(2);
  endtask

  task automatic test_raw_32bit_with_id();
    send_header(1'b1, 8'd3, KindRawGray, 16'd1, 16'd2, Depth32);
    send_rand_bytes(3);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1);
  endtask

  task automatic test_rle_packets();
    send_header(1'b1, 8'd0, 8'd10, 16'd4, 16'd2, Depth24);
    send_byte(8'h83, 1'b0);
    send_rand_pixels(1, 1'b0);
    send_byte(8'h02, 1'b0);
    send_rand_pixels(3, 1'b0);
    send_byte(8'h80, 1'b0);
    send_rand_pixels(1, 1'b0);
    // image done: these must be dropped
    send_rand_bytes(3);
  endtask

  task automatic test_clipped_runs();
    send_header(1'b1, 8'd0, 8'd10, 16'd2, 16'd2, Depth32);
    send_byte(8'hFF, 1'b0);
    send_rand_pixels(1, 1'b1);
    send_header(1'b1, 8'd0, 8'd9, 16'd1, 16'd2, Depth24);
    send_byte(8'h05, 1'b0);
    send_rand_pixels(2, 1'b0);
    send_rand_bytes(4);
  endtask

  task automatic test_header_errors();
    send_header(1'b1, 8'd0, KindRawColor, 16'd3, 16'd3, 8'd16);
    send_header(1'b1, 8'd0, KindRawColor, 16'd3, 16'd3, 8'd0);
    send_header(1'b1, 8'd0, KindRawColor, 16'd0, 16'd0, 8'hFF);
    send_header(1'b1, 8'd0, 8'd10, 16'd0, 16'd5, Depth24);
    send_header(1'b1, 8'd4, 8'd10, 16'd7, 16'd0, Depth32);
    send_rand_bytes(2);
  endtask

  task automatic test_frame_restart();
    send_header(1'b1, 8'd0, KindRawColor, 16'd4, 16'd4, Depth24);
    send_rand_pixels(1, 1'b0);
    send_byte(8'h5A, 1'b0);
    // abort mid-pixel, then abort again mid-header
    send_byte(8'd0, 1'b1);
    send_rand_bytes(6);
    send_header(1'b1, 8'd0, 8'd10, 16'd1, 16'd1, Depth32);
    send_byte(8'h80, 1'b0);
    send_rand_pixels(1, 1'b1);
  endtask

  // largest header fields; the image is abandoned by the next frame start
  task automatic test_header_extremes();
    send_header(1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, Depth32);
    send_rand_bytes(255);
    send_byte(8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_rand_pixels(4, 1'b1);
  endtask

  task automatic send_rand_image();
    logic [7:0]  id_len;
    logic [7:0]  kind;
    logic [7:0]  depth;
    logic [15:0] w;
    logic [15:0] h;
    bit          wide;
    int unsigned sel;
    int unsigned left;
    int unsigned budget;
    int unsigned n;
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(8, 24)) send_byte(8'($urandom), $urandom_range(15) == 0);
    end
    sel = $urandom_range(99);
    if (sel < 30)      kind = KindRawColor;
    else if (sel < 50) kind = KindRawGray;
    else if (sel < 90) kind = 8'($urandom_range(9, 11));
    else               kind = 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 45)      depth = Depth24;
    else if (sel < 90) depth = Depth32;
    else               depth = 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 5)       w = '0;
    else if (sel < 10) w = 16'($urandom);
    else               w = 16'($urandom_range(1, 6));
    sel = $urandom_range(99);
    if (sel < 5)       h = '0;
    else if (sel < 8)  h = 16'($urandom);
    else               h = 16'($urandom_range(1, 4));
    sel = $urandom_range(99);
    if (sel < 70)      id_len = '0;
    else if (sel < 97) id_len = 8'($urandom_range(1, 6));
    else               id_len = 8'($urandom);

    send_header(1'b1, id_len, kind, w, h, depth);
    left = 32'(w) * 32'(h);
    if ((depth == Depth24 || depth == Depth32) && left != 0) begin
      send_rand_bytes(id_len);
      wide   = (depth == Depth32);
      // now and then cut the image short; the next frame start aborts it
      budget = ($urandom_range(11) == 0) ? $urandom_range(0, 3) : 48;
      if (kind == KindRawColor || kind == KindRawGray) begin
        send_rand_pixels(left < budget ? left : budget, wide);
      end else begin
        while (left > 0 && budget > 0) begin
          if ($urandom_range(9) < 5) begin
            if ($urandom_range(19) == 0) n = $urandom_range(1, 128);
            else                         n = $urandom_range(1, left < 128 ? left : 128);
            send_byte(8'(n + 127), 1'b0);
            send_rand_pixels(1, wide);
            left   = left - (n < left ? n : left);
            budget = budget - 1;
          end else begin
            if ($urandom_range(19) == 0) n = $urandom_range(1, 16);
            else                         n = $urandom_range(1, left < 8 ? left : 8);
            send_byte(8'(n - 1), 1'b0);
            n = (n < left) ? n : left;
            n = (n < budget) ? n : budget;
            send_rand_pixels(n, wide);
            left   = left - n;
            budget = budget - n;
          end
        end
      end
    end
    if ($urandom_range(9) == 0) send_rand_bytes($urandom_range(1, 4));
  endtask

  task automatic test_random_images();
    int unsigned target;
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      target = decoded_bytes + 40;
      while (decoded_bytes < target) send_rand_image();
      drain_pixels();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    decoded_bytes  = 0;
    pixels_checked = 0;
    mismatches     = 0;
    cycle_count    = 0;
    dec_phase      = PH_HEADER;
    hdr_pos        = '0;
    id_left        = '0;
    img_kind       = '0;
    bits_pp        = '0;
    img_w          = '0;
    img_h          = '0;
    px_left        = '0;
    pkt_left       = '0;
    pkt_run        = 1'b0;
    px_byte        = '0;
    px_buf         = '{default: '0};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_no_frame_start();
    test_raw_32bit_with_id();
    test_rle_packets();
    test_clipped_runs();
    test_header_errors();
    test_frame_restart();
    test_header_extremes();
    drain_pixels();
    test_random_images();

    drain_pixels();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered raw and RLE images at 24 and 32 bits, ID skips, clipped runs,");
    $display("bad depths, empty images and restarts: %0d bytes decoded, %0d pixels checked",
             decoded_bytes, pixels_checked);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d pixels never seen", mismatches, pending_pixels.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
